>>> sv/pisd_pkg.sv
`timescale 1ns / 1ps

package pisd_pkg;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam logic [2:0] REG_KP         = 3'd0;
  localparam logic [2:0] REG_KI         = 3'd1;
  localparam logic [2:0] REG_BASE_SPEED = 3'd2;
  localparam logic [2:0] REG_TURN_STEP  = 3'd3;
  localparam logic [2:0] REG_INNER_CUT  = 3'd4;

  localparam logic [15:0] KP_RST         = 16'd16384;
  localparam logic [15:0] KI_RST         = 16'd41;
  localparam logic [15:0] BASE_SPEED_RST = 16'd40000;
  localparam logic [15:0] TURN_STEP_RST  = 16'd6000;
  localparam logic [15:0] INNER_CUT_RST  = 16'd7000;

  // Largest duty either wheel may get
  localparam logic [15:0] MAX_DUTY = 16'd65535;

  // Controller output is Q.20; whole steps are capped at four
  localparam int          FRAC_BITS  = 20;
  localparam int          U_W        = 50;
  localparam logic [2:0]  STEP_LIMIT = 3'd4;

  typedef struct packed {
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] base_speed;
    logic [15:0] turn_step;
    logic [15:0] inner_cut;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       right;
    logic [2:0] steps;
  } steer_t;

endpackage

>>> sv/pisd_cfg_regs.sv
`timescale 1ns / 1ps

module pisd_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [4:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output pisd_pkg::cfg_t   cfg
);

  pisd_pkg::cfg_t cfg_r;
  pisd_pkg::cfg_t cfg_nxt;
  logic [2:0]     idx;
  logic           wr_en;

  assign idx        = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        pisd_pkg::REG_KP:         cfg_nxt.kp         = cfg_pwdata[15:0];
        pisd_pkg::REG_KI:         cfg_nxt.ki         = cfg_pwdata[15:0];
        pisd_pkg::REG_BASE_SPEED: cfg_nxt.base_speed = cfg_pwdata[15:0];
        pisd_pkg::REG_TURN_STEP:  cfg_nxt.turn_step  = cfg_pwdata[15:0];
        pisd_pkg::REG_INNER_CUT:  cfg_nxt.inner_cut  = cfg_pwdata[15:0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pisd_pkg::REG_KP:         cfg_prdata = {16'd0, cfg_r.kp};
      pisd_pkg::REG_KI:         cfg_prdata = {16'd0, cfg_r.ki};
      pisd_pkg::REG_BASE_SPEED: cfg_prdata = {16'd0, cfg_r.base_speed};
      pisd_pkg::REG_TURN_STEP:  cfg_prdata = {16'd0, cfg_r.turn_step};
      pisd_pkg::REG_INNER_CUT:  cfg_prdata = {16'd0, cfg_r.inner_cut};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp         <= pisd_pkg::KP_RST;
      cfg_r.ki         <= pisd_pkg::KI_RST;
      cfg_r.base_speed <= pisd_pkg::BASE_SPEED_RST;
      cfg_r.turn_step  <= pisd_pkg::TURN_STEP_RST;
      cfg_r.inner_cut  <= pisd_pkg::INNER_CUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> sv/pisd_pi_law.sv
`timescale 1ns / 1ps

module pisd_pi_law (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 accept,
  input  logic signed [15:0]   line_error,
  input  pisd_pkg::cfg_t       cfg,
  output pisd_pkg::steer_t     steer
);

  // Stage 1: sample and the running sum it sees
  logic               v1_r;
  logic signed [15:0] e_r;
  logic signed [31:0] es_r;
  logic signed [31:0] err_sum_r;
  logic signed [31:0] err_sum_nxt;
  logic signed [32:0] sum_wide;

  // Stage 2: the two products
  logic               v2_r;
  logic signed [32:0] p_r;
  logic signed [32:0] p_nxt;
  logic signed [48:0] q_r;
  logic signed [48:0] q_nxt;

  // Stage 3: direction and step count
  pisd_pkg::steer_t              steer_r;
  pisd_pkg::steer_t              steer_nxt;
  logic signed [pisd_pkg::U_W-1:0] u;
  logic [pisd_pkg::U_W-1:0]        mag;

  assign sum_wide = {err_sum_r[31], err_sum_r} + {{17{line_error[15]}}, line_error};

  always_comb begin
    err_sum_nxt = sum_wide[31:0];
    if (sum_wide[32] != sum_wide[31]) begin
      err_sum_nxt = sum_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  assign p_nxt = $signed({1'b0, cfg.kp}) * e_r;
  assign q_nxt = $signed({1'b0, cfg.ki}) * es_r;

  always_comb begin
    u   = {{(pisd_pkg::U_W-33){p_r[32]}}, p_r} + {{(pisd_pkg::U_W-49){q_r[48]}}, q_r};
    steer_nxt.valid = v2_r;
    steer_nxt.right = !u[pisd_pkg::U_W-1] && (u != '0);
    mag = steer_nxt.right ? u : -u;
    if (mag[pisd_pkg::U_W-1:pisd_pkg::FRAC_BITS+2] != '0) begin
      steer_nxt.steps = pisd_pkg::STEP_LIMIT;
    end else begin
      steer_nxt.steps = mag[pisd_pkg::FRAC_BITS+2:pisd_pkg::FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      steer_r.valid <= 1'b0;
      err_sum_r     <= '0;
    end else if (adv) begin
      v1_r    <= accept;
      v2_r    <= v1_r;
      steer_r <= steer_nxt;
      if (accept) begin
        err_sum_r <= err_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r  <= line_error;
      es_r <= err_sum_r;
      p_r  <= p_nxt;
      q_r  <= q_nxt;
    end
  end

  assign steer = steer_r;

endmodule

>>> sv/pisd_drive_mix.sv
`timescale 1ns / 1ps

module pisd_drive_mix (
  input  logic               clk,
  input  logic               rst_n,
  input  pisd_pkg::steer_t   steer,
  input  pisd_pkg::cfg_t     cfg,
  output logic               adv,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,
  output logic               out_tuser
);

  logic               out_valid_r;
  logic [15:0]        left_r;
  logic [15:0]        left_nxt;
  logic [15:0]        right_r;
  logic [15:0]        right_nxt;
  logic               turn_r;
  logic [17:0]        add;
  logic [18:0]        outer;
  logic signed [19:0] inner;
  logic [15:0]        outer_duty;
  logic [15:0]        inner_duty;

  // Hold everything while a word waits on the output
  assign adv = !out_valid_r || out_tready;

  // steps is at most four: shift-and-add instead of a multiplier
  assign add = (steer.steps[2] ? {cfg.turn_step, 2'b00}        : 18'd0)
             + (steer.steps[1] ? {1'b0, cfg.turn_step, 1'b0}   : 18'd0)
             + (steer.steps[0] ? {2'b00, cfg.turn_step}        : 18'd0);

  assign outer = {3'b000, cfg.base_speed} + {1'b0, add};
  assign inner = $signed({4'b0000, cfg.base_speed}) - $signed({2'b00, add})
               - $signed({4'b0000, cfg.inner_cut});

  always_comb begin
    if (outer > {3'b000, pisd_pkg::MAX_DUTY}) begin
      outer_duty = pisd_pkg::MAX_DUTY;
    end else begin
      outer_duty = outer[15:0];
    end
    if (inner < 20'sd0) begin
      inner_duty = 16'd0;
    end else if (inner > $signed({4'b0000, pisd_pkg::MAX_DUTY})) begin
      inner_duty = pisd_pkg::MAX_DUTY;
    end else begin
      inner_duty = inner[15:0];
    end
    left_nxt  = steer.right ? outer_duty : inner_duty;
    right_nxt = steer.right ? inner_duty : outer_duty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= steer.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      turn_r  <= steer.right;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {right_r, left_r};
  assign out_tuser  = turn_r;

endmodule

>>> sv/pi_steering_differential_drive_core.sv
// PI steering core for a differential-drive line follower. Each input word
// carries one signed Q8.8 line error; each output word carries the left and
// right wheel duties and a turn-right flag. The controller output is
// kp*error + ki*sum, where sum is the saturating 32-bit total of all earlier
// errors (the current error joins it only after its own output is formed).
// The output is clamped to +-4, truncated toward zero to a step count, and
// each step adds turn_step to the outer wheel; the inner wheel gets
// base_speed minus that amount minus inner_cut, floored at zero, and both
// duties are capped at the maximum duty. A zero output steers left. The core
// takes one word per clock unless the output stalls and runs it through the
// sample register, product register (one 17x16 and one 17x32 multiplier),
// step register and the output register. A stall on the output holds the
// whole pipeline, so in_tready follows out_tready while the output register
// is full. Gains and speeds sit on a small register port at byte offsets
// 0x00 kp, 0x04 ki, 0x08 base_speed, 0x0C turn_step, 0x10 inner_cut; change
// them only while no word is in flight.
`timescale 1ns / 1ps

module pi_steering_differential_drive_core (
  input  logic        clk,
  input  logic        rst_n,
  // error stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] line_error
  // duty stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [15:0] left_duty, [31:16] right_duty
  output logic        out_tuser,   // [0] turning_right
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  pisd_pkg::cfg_t   cfg;
  pisd_pkg::steer_t steer;
  logic             adv;
  logic             accept;

  // Take a word whenever the pipeline moves
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;

  pisd_cfg_regs u_cfg_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Accumulate the error and form direction plus whole steps
  pisd_pi_law u_pi_law (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .accept     (accept),
    .line_error ($signed(in_tdata)),
    .cfg        (cfg),
    .steer      (steer)
  );

  // Turn steps into wheel duties and hold the output word
  pisd_drive_mix u_drive_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .steer      (steer),
    .cfg        (cfg),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
